FILE: hw/rtl/rmrs_pkg.sv
// types, codes and scan token for the rate-monotonic ready scheduler
// depends on nothing; used by the slot cell and the top level

package rmrs_pkg;

    localparam int unsigned ID_W     = 8;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;

    // event codes carried in req_type
    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_ENQUEUE  = 2'd1,
        REQ_DEQUEUE  = 2'd2,
        REQ_CHECK    = 2'd3
    } t_req_code;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOREG    = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUP      = 3'd3,
        ST_NOTREADY = 3'd4
    } t_status;

    // update broadcast to every cell
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REGISTER,
        OP_ENQUEUE,
        OP_DEQUEUE
    } t_cell_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH1,
        S_SCAN1,
        S_UPDATE,
        S_LAUNCH2,
        S_SCAN2,
        S_RESULT
    } t_state;

    // input beat
    typedef struct packed {
        logic [1:0]          req_type;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] task_period;
        logic                task_exiting;
        logic                running_is_rms;
        logic [ID_W-1:0]     running_id;
    } t_req_beat;

    // output beat
    typedef struct packed {
        logic                pick_valid;
        logic [ID_W-1:0]     pick_id;
        logic [PERIOD_W-1:0] pick_period;
        logic                resched;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  ready_count;
    } t_rsp_beat;

    // command seen by all cells at once
    typedef struct packed {
        t_cell_op            op;
        logic [ID_W-1:0]     task_id;
        logic [ID_W-1:0]     run_id;
        logic [PERIOD_W-1:0] period;
        logic [STAMP_W-1:0]  stamp_now;
        logic                exiting;
    } t_cell_cmd;

    // token handed from cell to cell along the chain
    typedef struct packed {
        logic                valid;
        logic                task_found;
        logic                task_ready;
        logic                free_found;
        logic                run_found;
        logic [PERIOD_W-1:0] run_period;
        logic                best_valid;
        logic [ID_W-1:0]     best_id;
        logic [PERIOD_W-1:0] best_period;
        logic [STAMP_W-1:0]  best_age;
    } t_scan;

endpackage

FILE: hw/rtl/rmrs_chan_if.sv
// valid/ready channel carrying one beat of a given payload type
// payload types come from rmrs_pkg

interface rmrs_chan_if #(
    parameter type t_beat = logic
);
    logic  valid;
    logic  ready;
    t_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rate_monotonic_ready_scheduler.sv
// top level of the rate-monotonic ready scheduler: sequencer, counters and cell chain
// depends on rmrs_pkg, rmrs_chan_if and rmrs_cell
//
// Usage
//   i_req takes one event beat (register, enqueue, dequeue or preemption check);
//   o_rsp gives one result beat per event: the ready task with the shortest
//   period (ties to the earliest enqueued), the ready count, a status and, for a
//   preemption check, the reschedule request.
//   Each event makes two passes of a token down a chain of MAX_TASKS slot cells,
//   one cell per cycle: a lookup pass before the table update and a pick pass
//   after it. i_req.ready is high only while no event is in progress, so a
//   new event waits until the previous result is in the output register.
//   The result sits in an output register, so the next event is taken while the
//   previous result still waits; if the receiver stalls long enough the finished
//   result is held inside until the output register frees up.
//   Reset (synchronous, active low) empties the table and clears the enqueue
//   stamp and ready count at once; no beat is lost or made up by a stall.

module rate_monotonic_ready_scheduler #(
    parameter int unsigned MAX_TASKS = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    rmrs_chan_if.sink    i_req,
    rmrs_chan_if.source  o_rsp
);

    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam int unsigned EW = (CW > rmrs_pkg::COUNT_W) ? CW : rmrs_pkg::COUNT_W;

    rmrs_pkg::t_state              r_state, n_state;
    rmrs_pkg::t_req_beat           r_req, n_req;
    rmrs_pkg::t_scan               r_look, n_look;
    rmrs_pkg::t_status             r_status, n_status;
    rmrs_pkg::t_rsp_beat           r_res, n_res;
    rmrs_pkg::t_rsp_beat           r_out, n_out;
    logic                          r_out_valid, n_out_valid;
    logic [rmrs_pkg::STAMP_W-1:0]  r_stamp_counter, n_stamp_counter;
    logic [CW-1:0]                 r_ready_total, n_ready_total;

    rmrs_pkg::t_cell_cmd           w_cmd;
    rmrs_pkg::t_scan               w_tok [MAX_TASKS+1];
    rmrs_pkg::t_scan               w_tail;
    logic                          w_start;
    logic [EW-1:0]                 w_count_ext;

    // chain of slot cells
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        rmrs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // fresh token at the head of the chain
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_start;
    end

    assign w_tail      = w_tok[MAX_TASKS];
    assign w_count_ext = EW'(r_ready_total);

    // sequencer: next state, table command and result
    always_comb begin
        n_state         = r_state;
        n_req           = r_req;
        n_look          = r_look;
        n_status        = r_status;
        n_res           = r_res;
        n_out           = r_out;
        n_out_valid     = r_out_valid;
        n_stamp_counter = r_stamp_counter;
        n_ready_total   = r_ready_total;
        w_start         = 1'b0;

        w_cmd.op        = rmrs_pkg::OP_NONE;
        w_cmd.task_id   = r_req.task_id;
        w_cmd.run_id    = r_req.running_id;
        w_cmd.period    = r_req.task_period;
        w_cmd.stamp_now = r_stamp_counter;
        w_cmd.exiting   = r_req.task_exiting;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rmrs_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.payload;
                    n_state = rmrs_pkg::S_LAUNCH1;
                end
            end
            rmrs_pkg::S_LAUNCH1: begin
                w_start = 1'b1;
                n_state = rmrs_pkg::S_SCAN1;
            end
            rmrs_pkg::S_SCAN1: begin
                if (w_tail.valid) begin
                    n_look  = w_tail;
                    n_state = rmrs_pkg::S_UPDATE;
                end
            end
            rmrs_pkg::S_UPDATE: begin
                n_status = rmrs_pkg::ST_OK;
                unique case (rmrs_pkg::t_req_code'(r_req.req_type))
                    rmrs_pkg::REQ_REGISTER: begin
                        if (r_look.task_found) begin
                            n_status = rmrs_pkg::ST_DUP;
                        end else if (!r_look.free_found) begin
                            n_status = rmrs_pkg::ST_FULL;
                        end else begin
                            w_cmd.op = rmrs_pkg::OP_REGISTER;
                        end
                    end
                    rmrs_pkg::REQ_ENQUEUE: begin
                        if (!r_look.task_found) begin
                            n_status = rmrs_pkg::ST_NOREG;
                        end else if (r_look.task_ready) begin
                            n_status = rmrs_pkg::ST_DUP;
                        end else begin
                            w_cmd.op        = rmrs_pkg::OP_ENQUEUE;
                            n_stamp_counter = r_stamp_counter + rmrs_pkg::STAMP_W'(1);
                            n_ready_total   = r_ready_total + CW'(1);
                        end
                    end
                    rmrs_pkg::REQ_DEQUEUE: begin
                        if (!r_look.task_found) begin
                            n_status = rmrs_pkg::ST_NOREG;
                        end else begin
                            w_cmd.op = rmrs_pkg::OP_DEQUEUE;
                            if (r_look.task_ready) begin
                                n_ready_total = r_ready_total - CW'(1);
                            end else begin
                                n_status = rmrs_pkg::ST_NOTREADY;
                            end
                        end
                    end
                    rmrs_pkg::REQ_CHECK: begin
                    end
                endcase
                n_state = rmrs_pkg::S_LAUNCH2;
            end
            rmrs_pkg::S_LAUNCH2: begin
                w_start = 1'b1;
                n_state = rmrs_pkg::S_SCAN2;
            end
            rmrs_pkg::S_SCAN2: begin
                if (w_tail.valid) begin
                    n_res.pick_valid  = w_tail.best_valid;
                    n_res.pick_id     = w_tail.best_id;
                    n_res.pick_period = w_tail.best_period;
                    n_res.resched     = 1'b0;
                    n_res.status      = r_status;
                    n_res.ready_count = w_count_ext[rmrs_pkg::COUNT_W-1:0];
                    // preemption check against the running task
                    if (r_req.req_type == rmrs_pkg::REQ_CHECK) begin
                        if (!r_req.running_is_rms) begin
                            n_res.resched = 1'b1;
                        end else if (w_tail.best_valid) begin
                            if (!r_look.run_found) begin
                                n_res.status = rmrs_pkg::ST_NOREG;
                            end else if (w_tail.best_period < r_look.run_period) begin
                                n_res.resched = 1'b1;
                            end
                        end
                    end
                    n_state = rmrs_pkg::S_RESULT;
                end
            end
            rmrs_pkg::S_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = rmrs_pkg::S_IDLE;
                end
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= rmrs_pkg::S_IDLE;
            r_out_valid     <= 1'b0;
            r_stamp_counter <= '0;
            r_ready_total   <= '0;
            r_status        <= rmrs_pkg::ST_OK;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_stamp_counter <= n_stamp_counter;
            r_ready_total   <= n_ready_total;
            r_status        <= n_status;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_look <= n_look;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // no beat is taken while reset is held
    assign i_req.ready   = i_rst_n && (r_state == rmrs_pkg::S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

FILE: hw/rtl/rmrs_cell.sv
// one task slot of the scheduler table and its stage of the scan chain
// depends on rmrs_pkg

module rmrs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmrs_pkg::t_cell_cmd i_cmd,
    input  rmrs_pkg::t_scan    i_tok,
    output rmrs_pkg::t_scan    o_tok
);

    logic                          r_used;
    logic                          r_ready;
    logic [rmrs_pkg::ID_W-1:0]     r_task;
    logic [rmrs_pkg::PERIOD_W-1:0] r_period;
    logic [rmrs_pkg::STAMP_W-1:0]  r_stamp;
    logic                          r_hit;
    logic                          r_free_first;
    rmrs_pkg::t_scan               r_tok;
    rmrs_pkg::t_scan               n_tok;

    logic                          w_match;
    logic                          w_run_match;
    logic                          w_first_free;
    logic                          w_take;
    logic [rmrs_pkg::STAMP_W-1:0]  w_age;

    // fold this slot into the passing token
    always_comb begin
        w_match      = r_used && (r_task == i_cmd.task_id);
        w_run_match  = r_used && (r_task == i_cmd.run_id);
        w_first_free = !r_used && !i_tok.free_found;
        w_age        = i_cmd.stamp_now - r_stamp;
        w_take       = r_used && r_ready &&
                       (!i_tok.best_valid || (r_period < i_tok.best_period) ||
                        ((r_period == i_tok.best_period) && (w_age > i_tok.best_age)));

        n_tok            = i_tok;
        n_tok.task_found = i_tok.task_found | w_match;
        n_tok.free_found = i_tok.free_found | !r_used;
        if (w_match && !i_tok.task_found) begin
            n_tok.task_ready = r_ready;
        end
        if (w_run_match && !i_tok.run_found) begin
            n_tok.run_found  = 1'b1;
            n_tok.run_period = r_period;
        end
        if (w_take) begin
            n_tok.best_valid  = 1'b1;
            n_tok.best_id     = r_task;
            n_tok.best_period = r_period;
            n_tok.best_age    = w_age;
        end
    end

    // token stage, hit marks and slot update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok        <= '0;
            r_used       <= 1'b0;
            r_ready      <= 1'b0;
            r_hit        <= 1'b0;
            r_free_first <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_hit        <= w_match;
                r_free_first <= w_first_free;
            end
            unique case (i_cmd.op)
                rmrs_pkg::OP_REGISTER: begin
                    if (r_free_first) begin
                        r_used   <= 1'b1;
                        r_ready  <= 1'b0;
                        r_task   <= i_cmd.task_id;
                        r_period <= i_cmd.period;
                    end
                end
                rmrs_pkg::OP_ENQUEUE: begin
                    if (r_hit) begin
                        r_ready <= 1'b1;
                        r_stamp <= i_cmd.stamp_now;
                    end
                end
                rmrs_pkg::OP_DEQUEUE: begin
                    if (r_hit) begin
                        r_ready <= 1'b0;
                        if (i_cmd.exiting) begin
                            r_used <= 1'b0;
                        end
                    end
                end
                rmrs_pkg::OP_NONE: begin
                end
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule
